// File: src/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFBA_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfba: property violated");

// The consequent must hold in the cycle after the antecedent.
`define PFBA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfba: property violated");

`endif

// File: src/pfba_pkg.sv
// Shared constants and controller/datapath interface types of the page frame allocator.
package pfba_pkg;

   localparam int PAGE_COUNT   = 65536;
   localparam int MAP_BYTES    = (PAGE_COUNT + 7) / 8;
   localparam int BYTE_AW      = $clog2(MAP_BYTES);
   localparam int ADDR_W       = 32;
   localparam int PAGE_IN_W    = 16;
   localparam int START_BYTE_W = PAGE_IN_W - 3;
   localparam int CUR_W        = (BYTE_AW > START_BYTE_W) ? BYTE_AW : START_BYTE_W;
   localparam int PAGE_SHIFT   = 12;
   localparam int SUM_W        = ADDR_W + 2;
   localparam int SPAN_W       = SUM_W - PAGE_SHIFT;

   localparam logic [SUM_W-1:0] PAGE_MASK = SUM_W'(4095);
   localparam logic [7:0]       BYTE_FULL = 8'hFF;

   localparam logic [1:0] OP_RESERVE = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;
   localparam logic [1:0] OP_ALLOC   = 2'd3;

   localparam int         CSR_AW           = 3;
   localparam logic [0:0] REG_SEARCH_START = 1'b0;

   typedef struct packed {
      logic load;
      logic clr_wr;
      logic rmw_wr;
      logic step;
      logic take_query;
      logic take_frame;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       skip;
      logic       clear_last;
      logic       range_last;
      logic       byte_full;
      logic       alloc_last;
      logic       out_busy;
   } stat_type;

endpackage

// File: src/pfba_ctrl.sv
// Controller state machine: sequences clearing, range walks, queries and the allocation scan.
module pfba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pfba_pkg::stat_type stat,
   output pfba_pkg::cmd_type  cmd
);
   import pfba_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            cmd.step   = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = stat.skip ? S_DONE : S_EVAL;
         end
         S_EVAL: begin
            unique case (stat.op)
               OP_RESERVE, OP_FREE: begin
                  cmd.rmw_wr = 1'b1;
                  if (stat.range_last) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.step = 1'b1;
                     state_in = S_READ;
                  end
               end
               OP_QUERY: begin
                  cmd.take_query = 1'b1;
                  state_in       = S_DONE;
               end
               OP_ALLOC: begin
                  if (!stat.byte_full) begin
                     cmd.rmw_wr     = 1'b1;
                     cmd.take_frame = 1'b1;
                     state_in       = S_DONE;
                  end else if (stat.alloc_last) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.step = 1'b1;
                     state_in = S_READ;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// File: src/pfba_dpath.sv
// Datapath: bitmap memory, byte cursor, range bounds, result and output registers.
module pfba_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  pfba_pkg::cmd_type                cmd,
   output pfba_pkg::stat_type               stat,
   input  logic [1:0]                       req_op,
   input  logic [pfba_pkg::ADDR_W-1:0]      req_base_address,
   input  logic [pfba_pkg::ADDR_W-1:0]      req_range_length,
   input  logic [pfba_pkg::PAGE_IN_W-1:0]   req_page_index,
   input  logic [pfba_pkg::PAGE_IN_W-1:0]   search_start_page,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [pfba_pkg::ADDR_W-1:0]      rsp_frame_address,
   output logic                             rsp_found,
   output logic                             rsp_page_reserved
);
   import pfba_pkg::*;

   logic [7:0]        page_map_ff [MAP_BYTES];
   logic [7:0]        rd_data_ff;

   logic [1:0]        op_ff, op_in;
   logic              skip_ff, skip_in;
   logic [2:0]        sub_ff, sub_in;
   logic [SPAN_W-1:0] first_ff, first_in;
   logic [SPAN_W-1:0] last_ff, last_in;
   logic [CUR_W-1:0]  cur_ff, cur_in;

   logic [ADDR_W-1:0] res_frame_ff, res_frame_in;
   logic              res_found_ff, res_found_in;
   logic              res_reserved_ff, res_reserved_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_reserved_ff, rsp_reserved_in;

   logic [SUM_W-1:0]  base_w, len_w, lo_sum, hi_sum;
   logic [SPAN_W-1:0] first_raw, last_raw, last_clip;
   logic              range_empty, query_beyond, start_beyond;
   logic [7:0]        bit_mask, wr_data;
   logic [2:0]        low_idx;
   logic              wr_en;

   // Page bounds of a range: reserve widens to whole pages, free narrows.
   always_comb begin
      base_w = SUM_W'(req_base_address);
      len_w  = SUM_W'(req_range_length);
      if (req_op == OP_RESERVE) begin
         lo_sum = base_w;
         hi_sum = base_w + len_w + PAGE_MASK;
      end else begin
         lo_sum = base_w + PAGE_MASK;
         hi_sum = base_w + len_w;
      end
      first_raw    = lo_sum[SUM_W-1:PAGE_SHIFT];
      last_raw     = hi_sum[SUM_W-1:PAGE_SHIFT];
      last_clip    = (last_raw > SPAN_W'(PAGE_COUNT)) ? SPAN_W'(PAGE_COUNT) : last_raw;
      range_empty  = (first_raw >= last_clip);
      query_beyond = (32'(req_page_index) >= 32'(PAGE_COUNT));
      start_beyond = (32'(search_start_page >> 3) >= 32'(MAP_BYTES));
   end

   // Bits of the current byte that fall inside the range.
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         bit_mask[k] = (SPAN_W'({cur_ff, 3'(k)}) >= first_ff) &&
                       (SPAN_W'({cur_ff, 3'(k)}) <  last_ff);
      end
   end

   always_comb begin
      low_idx = '0;
      for (int k = 7; k >= 0; k--) begin
         if (!rd_data_ff[k]) begin
            low_idx = 3'(k);
         end
      end
   end

   always_comb begin
      unique case (op_ff)
         OP_RESERVE: wr_data = rd_data_ff | bit_mask;
         OP_FREE:    wr_data = rd_data_ff & ~bit_mask;
         OP_ALLOC:   wr_data = rd_data_ff | (8'd1 << low_idx);
         OP_QUERY:   wr_data = rd_data_ff;
         default:    wr_data = rd_data_ff;
      endcase
      if (cmd.clr_wr) begin
         wr_data = BYTE_FULL;
      end
      wr_en = cmd.clr_wr | cmd.rmw_wr;
   end

   always_comb begin
      op_in           = op_ff;
      skip_in         = skip_ff;
      sub_in          = sub_ff;
      first_in        = first_ff;
      last_in         = last_ff;
      cur_in          = cur_ff;
      res_frame_in    = res_frame_ff;
      res_found_in    = res_found_ff;
      res_reserved_in = res_reserved_ff;

      if (cmd.load) begin
         op_in           = req_op;
         sub_in          = req_page_index[2:0];
         first_in        = first_raw;
         last_in         = last_clip;
         res_frame_in    = '0;
         res_found_in    = 1'b0;
         res_reserved_in = (req_op == OP_QUERY) && query_beyond;
         unique case (req_op)
            OP_RESERVE, OP_FREE: begin
               skip_in = range_empty;
               cur_in  = CUR_W'(first_raw >> 3);
            end
            OP_QUERY: begin
               skip_in = query_beyond;
               cur_in  = CUR_W'(req_page_index >> 3);
            end
            OP_ALLOC: begin
               skip_in = start_beyond;
               cur_in  = CUR_W'(search_start_page >> 3);
            end
            default: begin
               skip_in = 1'b1;
               cur_in  = '0;
            end
         endcase
      end else if (cmd.step) begin
         cur_in = cur_ff + CUR_W'(1);
      end

      if (cmd.take_query) begin
         res_reserved_in = rd_data_ff[sub_ff];
      end
      if (cmd.take_frame) begin
         res_found_in = 1'b1;
         res_frame_in = ADDR_W'({cur_ff[BYTE_AW-1:0], low_idx}) << PAGE_SHIFT;
      end
   end

   // Output register: holds a finished transaction until the receiver takes it.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_frame_in    = rsp_frame_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_reserved_in = rsp_reserved_ff;
      if (cmd.emit) begin
         rsp_valid_in    = 1'b1;
         rsp_frame_in    = res_frame_ff;
         rsp_found_in    = res_found_ff;
         rsp_reserved_in = res_reserved_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_map_ff[cur_ff[BYTE_AW-1:0]] <= wr_data;
      end
      rd_data_ff <= page_map_ff[cur_ff[BYTE_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff           <= op_in;
      skip_ff         <= skip_in;
      sub_ff          <= sub_in;
      first_ff        <= first_in;
      last_ff         <= last_in;
      res_frame_ff    <= res_frame_in;
      res_found_ff    <= res_found_in;
      res_reserved_ff <= res_reserved_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_reserved_ff <= rsp_reserved_in;
   end

   always_comb begin
      stat.op         = op_ff;
      stat.skip       = skip_ff;
      stat.clear_last = (cur_ff == CUR_W'(MAP_BYTES - 1));
      stat.range_last = (SPAN_W'({({1'b0, cur_ff} + (CUR_W + 1)'(1)), 3'b000}) >= last_ff);
      stat.byte_full  = (rd_data_ff == BYTE_FULL);
      stat.alloc_last = (cur_ff == CUR_W'(MAP_BYTES - 1));
      stat.out_busy   = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_address = rsp_frame_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_page_reserved = rsp_reserved_ff;

endmodule

// File: src/page_frame_bitmap_allocator.sv
// Top level of the page frame bitmap allocator: register port, controller and datapath.
//
// The request channel (req_*) carries one transaction per operation: reserve a byte
// range, free a byte range, query one page, or allocate the first free frame. Every
// request transaction yields exactly one response transaction on the rsp_* channel.
// A transaction moves at a clock edge where valid is high and stall is low.
// The bitmap holds one bit per 4 KiB page in an 8192 x 8 memory, one read-modify-write
// port. Each bitmap byte touched is first read (READ state), then examined and written
// back (EVAL state). A query reads and examines one byte, a range operation each byte
// it covers (nothing when the range is empty), and an allocation each byte scanned
// from the byte holding search_start_page until a free bit or the last byte is found.
// A new request is taken only after the previous response has been emitted.
// Requests are handled one at a time; req_stall is high while one is in progress.
// A finished response sits in an output register, so a new request is taken while the
// receiver stalls; that request's response then waits until the register drains.
// After reset a clearing pass writes all ones into the map, one byte per cycle, and
// req_stall stays high until it finishes. Register writes are taken during that pass.
// search_start_page lives at byte address 0 of the register port and resets to 0.
module page_frame_bitmap_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [pfba_pkg::ADDR_W-1:0]       req_base_address,
   input  logic [pfba_pkg::ADDR_W-1:0]       req_range_length,
   input  logic [pfba_pkg::PAGE_IN_W-1:0]    req_page_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pfba_pkg::ADDR_W-1:0]       rsp_frame_address,
   output logic                              rsp_found,
   output logic                              rsp_page_reserved,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pfba_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import pfba_pkg::*;

   cmd_type              cmd;
   stat_type             stat;
   logic [PAGE_IN_W-1:0] start_page_ff, start_page_in;
   logic                 csr_hit;

   // The only register is decoded on word address bit; higher addresses read as zero.
   assign csr_hit    = (csr_paddr[2:2] == REG_SEARCH_START);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {{(32 - PAGE_IN_W){1'b0}}, start_page_ff} : 32'd0;

   always_comb begin
      start_page_in = start_page_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         start_page_in = csr_pwdata[PAGE_IN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_page_ff <= '0;
      end else begin
         start_page_ff <= start_page_in;
      end
   end

   pfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfba_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_op),
      .req_base_address  (req_base_address),
      .req_range_length  (req_range_length),
      .req_page_index    (req_page_index),
      .search_start_page (start_page_ff),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_frame_address (rsp_frame_address),
      .rsp_found         (rsp_found),
      .rsp_page_reserved (rsp_page_reserved)
   );

endmodule

// File: src/pfba_checker.sv
// Port-level assertion checker for the page frame allocator and its bind statement.
`include "assert_macros.svh"

module pfba_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [pfba_pkg::ADDR_W-1:0] rsp_frame_address,
   input logic                        rsp_found,
   input logic                        rsp_page_reserved
);

   // The clearing pass keeps requests out right after reset.
   `PFBA_ASSERT_NEXT(a_stall_after_reset, clock, 1'b0, reset, req_stall)

   // One request at a time: an accepted transaction blocks the next cycle.
   `PFBA_ASSERT_NEXT(a_stall_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A nonzero frame address only comes with a successful allocation.
   `PFBA_ASSERT_NOW(a_frame_needs_found, clock, reset,
      rsp_valid && (rsp_frame_address != '0), rsp_found)

   // An allocation response never carries a query status.
   `PFBA_ASSERT_NOW(a_found_not_query, clock, reset, rsp_valid && rsp_found, !rsp_page_reserved)

   // A stalled response stays offered.
   `PFBA_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind page_frame_bitmap_allocator pfba_checker u_pfba_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_frame_address (rsp_frame_address),
   .rsp_found         (rsp_found),
   .rsp_page_reserved (rsp_page_reserved)
);
